>>> hdl/sunr_pkg.sv
// sunr_pkg: shared types, constants and the count table builder for the subset unranker
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package sunr_pkg;

	localparam int MAX_ELEMS = 32;
	localparam int ROWLEN    = MAX_ELEMS + 1;
	localparam int ROM_DEPTH = ROWLEN * ROWLEN;
	localparam int ROM_AW    = $clog2(ROM_DEPTH);
	localparam int RANK_W    = 32;
	localparam int COUNT_W   = RANK_W + 1;
	localparam int VALUE_W   = 32;
	localparam int POS_W     = $clog2(MAX_ELEMS);
	localparam int SIZE_W    = 6;

	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 48;

	localparam logic [SIZE_W-1:0] SET_SIZE_RST = SIZE_W'(32);

	// request kinds on the input tuser
	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_UNRANK = 1'b1;

	// result status on the output tuser
	localparam logic STAT_OK    = 1'b0;
	localparam logic STAT_RANGE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INVAL,
		ST_SISSUE,
		ST_SCMP,
		ST_WSET,
		ST_WALK
	} sunr_state_t;

	typedef struct packed {
		logic              en;
		logic [ROM_AW-1:0] addr;
	} rom_rd_t;

	typedef struct packed {
		logic             en;
		logic [POS_W-1:0] addr;
	} base_rd_t;

	typedef logic [COUNT_W-1:0] count_rom_t [ROM_DEPTH];

	// row 0: 2^j; row a: C(a,j) for j <= a, tail counts for j > a
	function automatic count_rom_t build_counts();
		count_rom_t t;
		int idx;
		for (int j = 0; j < ROWLEN; j++) begin
			t[j] = COUNT_W'(1) << j;
		end
		for (int a = 1; a < ROWLEN; a++) begin
			for (int j = 0; j < ROWLEN; j++) begin
				idx = a * ROWLEN + j;
				if (j == 0 || j == a) begin
					t[idx] = COUNT_W'(1);
				end else if (a > j) begin
					t[idx] = t[(a - 1) * ROWLEN + j - 1] + t[(a - 1) * ROWLEN + j];
				end else begin
					t[idx] = t[a * ROWLEN + j - 1] + t[(a - 1) * ROWLEN + j - 1];
				end
			end
		end
		return t;
	endfunction

	function automatic logic [ROM_AW-1:0] rom_addr(input logic [SIZE_W-1:0] row,
			input logic [SIZE_W-1:0] col);
		return ROM_AW'(row) * ROM_AW'(ROWLEN) + ROM_AW'(col);
	endfunction

endpackage

`default_nettype wire

>>> hdl/sunr_count_rom.sv
// sunr_count_rom: binomial and tail-count table, two registered read ports
// depends on sunr_pkg
`timescale 1ns / 1ps
`default_nettype none

module sunr_count_rom import sunr_pkg::*; (
	input  wire logic               clk,
	input  wire rom_rd_t            rd_a,
	input  wire rom_rd_t            rd_b,
	output logic [COUNT_W-1:0]      data_a,
	output logic [COUNT_W-1:0]      data_b
);

	localparam count_rom_t COUNTS = build_counts();

	// out-of-range addresses only occur on speculative reads that are never used
	always_ff @(posedge clk) begin
		if (rd_a.en) begin
			data_a <= (rd_a.addr < ROM_AW'(ROM_DEPTH)) ? COUNTS[rd_a.addr] : '0;
		end
		if (rd_b.en) begin
			data_b <= (rd_b.addr < ROM_AW'(ROM_DEPTH)) ? COUNTS[rd_b.addr] : '0;
		end
	end

endmodule

`default_nettype wire

>>> hdl/sunr_base_ram.sv
// sunr_base_ram: base value store, one write port and one registered read port
// depends on sunr_pkg
`timescale 1ns / 1ps
`default_nettype none

module sunr_base_ram import sunr_pkg::*; (
	input  wire logic               clk,
	input  wire logic               wr_en,
	input  wire logic [POS_W-1:0]   wr_addr,
	input  wire logic [VALUE_W-1:0] wr_data,
	input  wire base_rd_t           rd,
	output logic [VALUE_W-1:0]      rd_data
);

	logic [VALUE_W-1:0] mem [MAX_ELEMS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/subset_unranker.sv
// subset unranker: a load request (tuser 0) writes one base entry. an unrank request (tuser 1)
// maps index N to a subset of the first L base entries, ordered by size and then lexicographically
// by position, and returns one transfer per chosen element in position order, tlast on the final
// one. N = 0 or N >= 2^L gives a single transfer with tuser 1 and zero data. the size search is a
// binary search whose every step waits on the registered count table read, and the position walk
// retires one position per cycle, both candidate coefficients for the next position being read
// ahead on the table's two ports. downstream back-pressure stretches the walk. the set size
// register is written through cfg_valid/cfg_data; the user must write it only while the block is
// idle, as the block itself does not enforce this.
// top level of the unranker; depends on sunr_pkg, sunr_count_rom and sunr_base_ram
`timescale 1ns / 1ps
`default_nettype none

module subset_unranker import sunr_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// request stream
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// slot [4:0], value [36:5], rank_index [68:37], zero pad above
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// req_type [0]
	input  wire logic                   s_axis_tuser,
	// result stream
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// elem_value [31:0], elem_pos [36:32], subset_size [42:37], zero pad above
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
	// status [0]
	output logic                        m_axis_tuser,
	output logic                        m_axis_tlast,
	// set size register write
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [SIZE_W-1:0]      cfg_data
);

	// request fields
	logic [POS_W-1:0]   in_slot;
	logic [VALUE_W-1:0] in_value;
	logic [RANK_W-1:0]  in_rank;

	assign in_slot  = s_axis_tdata[POS_W-1:0];
	assign in_value = s_axis_tdata[POS_W+VALUE_W-1:POS_W];
	assign in_rank  = s_axis_tdata[POS_W+VALUE_W+RANK_W-1:POS_W+VALUE_W];

	sunr_state_t state_q, state_d;

	logic [SIZE_W-1:0]  set_size_q;
	logic [SIZE_W-1:0]  l_q;          // effective set size of the current request
	logic [RANK_W-1:0]  req_n_q;      // requested index
	logic [SIZE_W-1:0]  lo_q, hi_q;   // size search bounds
	logic [COUNT_W-1:0] hv_q;         // tail count at hi_q
	logic [SIZE_W-1:0]  s_q;          // subset size
	logic [SIZE_W-1:0]  col_q;        // picks still to make after the current one
	logic [SIZE_W-1:0]  k_q;          // walk step, position + 1
	logic [SIZE_W-1:0]  m_q;          // index of the next pick
	logic [RANK_W-1:0]  n_q;          // remaining offset
	logic               sel_b_q;      // coefficient of this step sits on port b

	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [POS_W-1:0]   out_pos_q;
	logic [SIZE_W-1:0]  out_size_q;
	logic               out_status_q;
	logic               out_last_q;

	rom_rd_t            rom_a, rom_b;
	logic [COUNT_W-1:0] rom_data_a, rom_data_b;
	base_rd_t           base_rd;
	logic [VALUE_W-1:0] base_data;

	logic               in_acc;
	logic               base_wr;
	logic [SIZE_W-1:0]  l_eff;
	logic               req_bad;
	logic [SIZE_W:0]    mid_sum;
	logic [SIZE_W-1:0]  mid;
	logic [SIZE_W-1:0]  row_nx;
	logic [COUNT_W-1:0] walk_c;
	logic               walk_keep;
	logic               walk_done;
	logic               walk_adv;
	logic               out_free;
	logic               out_wr;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// load requests go straight into the base store
	assign base_wr = in_acc && (s_axis_tuser == REQ_LOAD)
		&& ({1'b0, in_slot} < (POS_W + 1)'(MAX_ELEMS));

	// set size saturates at the store depth; index must lie in [1, 2^L - 1]
	assign l_eff   = (set_size_q > SIZE_W'(MAX_ELEMS)) ? SIZE_W'(MAX_ELEMS) : set_size_q;
	assign req_bad = (in_rank == '0) || ({1'b0, in_rank} >= (COUNT_W'(1) << l_eff));

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[SIZE_W:1];

	// walk: keep the position when the offset is below C(positions left, picks left)
	assign row_nx    = l_q - k_q - SIZE_W'(1);
	assign walk_c    = sel_b_q ? rom_data_b : rom_data_a;
	assign walk_keep = ({1'b0, n_q} < walk_c);
	assign walk_done = (walk_keep && (m_q == s_q)) || (k_q == l_q);

	assign out_free = !out_valid_q || m_axis_tready;

	sunr_count_rom u_count_rom (
		.clk    (clk),
		.rd_a   (rom_a),
		.rd_b   (rom_b),
		.data_a (rom_data_a),
		.data_b (rom_data_b)
	);

	sunr_base_ram u_base_ram (
		.clk     (clk),
		.wr_en   (base_wr),
		.wr_addr (in_slot),
		.wr_data (in_value),
		.rd      (base_rd),
		.rd_data (base_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: accept, range check, size search, then one position per cycle unless a kept element waits on the output
	always_comb begin
		state_d  = state_q;
		rom_a    = '0;
		rom_b    = '0;
		base_rd  = '0;
		out_wr   = 1'b0;
		walk_adv = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (s_axis_tuser == REQ_UNRANK)) begin
					state_d = req_bad ? ST_INVAL : ST_SISSUE;
				end
			end
			ST_INVAL: begin
				if (out_free) begin
					out_wr  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SISSUE: begin
				if (lo_q == hi_q) begin
					state_d = ST_WSET;
				end else begin
					rom_a.en   = 1'b1;
					rom_a.addr = rom_addr(mid, l_q);
					state_d    = ST_SCMP;
				end
			end
			ST_SCMP: begin
				state_d = ST_SISSUE;
			end
			ST_WSET: begin
				// prime the first coefficient and the first base entry
				rom_a.en     = 1'b1;
				rom_a.addr   = rom_addr(l_q - SIZE_W'(1), col_q);
				base_rd.en   = 1'b1;
				base_rd.addr = '0;
				state_d      = ST_WALK;
			end
			ST_WALK: begin
				if (!walk_keep || out_free) begin
					walk_adv = 1'b1;
					out_wr   = walk_keep;
					if (walk_done) begin
						state_d = ST_IDLE;
					end else begin
						// both candidates for the next step: skip on port a, keep on port b
						rom_a.en     = 1'b1;
						rom_a.addr   = rom_addr(row_nx, col_q);
						rom_b.en     = 1'b1;
						rom_b.addr   = rom_addr(row_nx, col_q - SIZE_W'(1));
						base_rd.en   = 1'b1;
						base_rd.addr = k_q[POS_W-1:0];
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q <= SET_SIZE_RST;
			l_q        <= '0;
			req_n_q    <= '0;
			lo_q       <= '0;
			hi_q       <= '0;
			hv_q       <= '0;
			s_q        <= '0;
			col_q      <= '0;
			k_q        <= '0;
			m_q        <= '0;
			n_q        <= '0;
			sel_b_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				set_size_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (s_axis_tuser == REQ_UNRANK)) begin
						l_q     <= l_eff;
						req_n_q <= in_rank;
						lo_q    <= SIZE_W'(1);
						hi_q    <= l_eff;
						hv_q    <= COUNT_W'(1);
					end
				end
				ST_SISSUE: begin
					if (lo_q == hi_q) begin
						s_q   <= l_q - hi_q + SIZE_W'(1);
						col_q <= l_q - hi_q;
						n_q   <= req_n_q - hv_q[RANK_W-1:0];
					end
				end
				ST_SCMP: begin
					// smallest h whose tail count does not exceed N
					if (rom_data_a <= {1'b0, req_n_q}) begin
						hi_q <= mid;
						hv_q <= rom_data_a;
					end else begin
						lo_q <= mid + SIZE_W'(1);
					end
				end
				ST_WSET: begin
					k_q     <= SIZE_W'(1);
					m_q     <= SIZE_W'(1);
					sel_b_q <= 1'b0;
				end
				ST_WALK: begin
					if (walk_adv) begin
						k_q     <= k_q + SIZE_W'(1);
						sel_b_q <= walk_keep;
						if (walk_keep) begin
							m_q   <= m_q + SIZE_W'(1);
							col_q <= col_q - SIZE_W'(1);
						end else begin
							n_q <= n_q - walk_c[RANK_W-1:0];
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// output register parts the walk from the downstream handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_wr) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_wr) begin
			if (state_q == ST_INVAL) begin
				out_value_q  <= '0;
				out_pos_q    <= '0;
				out_size_q   <= '0;
				out_status_q <= STAT_RANGE;
				out_last_q   <= 1'b1;
			end else begin
				out_value_q  <= base_data;
				out_pos_q    <= POS_W'(k_q - SIZE_W'(1));
				out_size_q   <= s_q;
				out_status_q <= STAT_OK;
				out_last_q   <= (m_q == s_q);
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - VALUE_W - POS_W - SIZE_W)'(0),
		out_size_q, out_pos_q, out_value_q};
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

	// walk counters stay inside the subset and the set
	a_walk_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (m_q <= s_q) && (k_q != '0) && (k_q <= l_q))
		else $error("walk counters out of range");

	// a compare step only follows an open search interval
	a_search_open: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCMP) |-> (lo_q < hi_q))
		else $error("size search compared with a closed interval");

	// the chosen tail count never exceeds the index
	a_tail_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WSET) |-> (hv_q != '0) && (hv_q <= {1'b0, req_n_q}))
		else $error("size search result exceeds the index");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_wr |-> out_free)
		else $error("result register overwritten");

	// an out-of-range result is a single, final, zeroed transfer
	a_range_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == STAT_RANGE)) |-> m_axis_tlast && (m_axis_tdata == '0))
		else $error("malformed out-of-range result");

endmodule

`default_nettype wire

>>> tb/sv/tb_subset_unranker.sv
// self-checking testbench for subset_unranker: stimulus table, then random load and unrank traffic
// predicts every element transfer from its own count table and base set copy; needs sunr_pkg and the rtl
`timescale 1ns / 1ps

module tb_subset_unranker;
	import sunr_pkg::*;

	localparam int SETTLE_CYC  = 60;    // extra idle cycles after the last expected transfer
	localparam int STALL_LIMIT = 2000;  // cycles without any transfer before giving up

	// one element transfer as the block should present it
	typedef struct packed {
		logic [31:0]       value;
		logic [POS_W-1:0]  pos;
		logic [SIZE_W-1:0] size;
		logic              status;
		logic              last;
	} elem_res_t;

	localparam elem_res_t RANGE_ERR_RES = '{value: '0, pos: '0, size: '0,
		status: STAT_RANGE, last: 1'b1};

	typedef enum logic [1:0] {ROW_LOAD, ROW_UNRANK, ROW_CFG} row_kind_t;

	// typed set: the result is a known out-of-range transfer, no prediction needed
	typedef struct packed {
		row_kind_t         kind;
		logic [POS_W-1:0]  slot;
		logic [31:0]       value;
		logic [31:0]       arg;
		logic              typed;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   s_axis_tuser  = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;
	logic                   m_axis_tlast;
	logic                   cfg_valid     = 1'b0;
	logic                   cfg_ready;
	logic [SIZE_W-1:0]      cfg_data      = '0;

	// predictor state: count table, base set copy and set size copy
	longint unsigned        cnt_tab [0:MAX_ELEMS][0:MAX_ELEMS];
	logic [31:0]            base_shadow [MAX_ELEMS];
	logic [SIZE_W-1:0]      size_shadow = SET_SIZE_RST;
	elem_res_t              pending_elems [$];
	int unsigned            mismatch_cnt = 0;
	int unsigned            tx_idle_pct = 20;
	int unsigned            rx_idle_pct = 75;

	// directed stimulus: extremes, both request kinds, each special case
	dir_row_t dir_tab [26] = '{
		'{ROW_UNRANK, 5'd0,  32'h0,         32'h0,         1'b1},  // index zero
		'{ROW_LOAD,   5'd0,  32'h8000_0000, 32'h0,         1'b0},  // most negative value
		'{ROW_LOAD,   5'd31, 32'h7FFF_FFFF, 32'h0,         1'b0},  // most positive, top slot
		'{ROW_LOAD,   5'd5,  32'h0,         32'h0,         1'b0},
		'{ROW_LOAD,   5'd6,  32'hFFFF_FFFF, 32'h0,         1'b0},
		'{ROW_UNRANK, 5'd0,  32'h0,         32'd1,         1'b0},  // first singleton
		'{ROW_UNRANK, 5'd0,  32'h0,         32'd32,        1'b0},  // last singleton
		'{ROW_UNRANK, 5'd0,  32'h0,         32'd33,        1'b0},  // first pair
		'{ROW_UNRANK, 5'd0,  32'h0,         32'hFFFF_FFFF, 1'b0},  // full set of 32
		'{ROW_UNRANK, 5'd0,  32'h0,         32'hFFFF_FFFE, 1'b0},
		'{ROW_CFG,    5'd0,  32'h0,         32'd1,         1'b0},  // smallest non-empty set
		'{ROW_UNRANK, 5'd0,  32'h0,         32'd1,         1'b0},
		'{ROW_UNRANK, 5'd0,  32'h0,         32'd2,         1'b1},  // just past 2^L - 1
		'{ROW_UNRANK, 5'd0,  32'h0,         32'hFFFF_FFFF, 1'b1},
		'{ROW_CFG,    5'd0,  32'h0,         32'd0,         1'b0},  // zero set size
		'{ROW_UNRANK, 5'd0,  32'h0,         32'd1,         1'b1},
		'{ROW_UNRANK, 5'd0,  32'h0,         32'hFFFF_FFFF, 1'b1},
		'{ROW_CFG,    5'd0,  32'h0,         32'd63,        1'b0},  // saturates to the maximum
		'{ROW_UNRANK, 5'd0,  32'h0,         32'hFFFF_FFFF, 1'b0},
		'{ROW_UNRANK, 5'd0,  32'h0,         32'd0,         1'b1},
		'{ROW_CFG,    5'd0,  32'h0,         32'd31,        1'b0},
		'{ROW_UNRANK, 5'd0,  32'h0,         32'h7FFF_FFFF, 1'b0},  // full set of 31
		'{ROW_UNRANK, 5'd0,  32'h0,         32'h8000_0000, 1'b1},
		'{ROW_CFG,    5'd0,  32'h0,         32'd2,         1'b0},
		'{ROW_UNRANK, 5'd0,  32'h0,         32'd3,         1'b0},
		'{ROW_UNRANK, 5'd0,  32'h0,         32'd4,         1'b1}
	};

	subset_unranker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// count table: row 0 holds 2^j, row a holds C(a,j) up to j = a and beyond that
	// the number of subsets of j items with at least a members
	initial begin : count_setup
		longint unsigned binom [0:MAX_ELEMS][0:MAX_ELEMS];
		longint unsigned acc;
		for (int n = 0; n <= MAX_ELEMS; n++) begin
			for (int k = 0; k <= MAX_ELEMS; k++) begin
				if (k == 0) begin
					binom[n][k] = 1;
				end else if (n == 0) begin
					binom[n][k] = 0;
				end else begin
					binom[n][k] = binom[n-1][k-1] + binom[n-1][k];
				end
			end
		end
		for (int a = 0; a <= MAX_ELEMS; a++) begin
			for (int j = 0; j <= MAX_ELEMS; j++) begin
				if (a == 0) begin
					cnt_tab[a][j] = 64'd1 << j;
				end else if (j <= a) begin
					cnt_tab[a][j] = binom[a][j];
				end else begin
					acc = 0;
					for (int i = a; i <= j; i++) acc += binom[j][i];
					cnt_tab[a][j] = acc;
				end
			end
		end
	end

	// expected element transfers of one unrank request, queued in position order
	function automatic void unrank_predict(input logic [31:0] rank);
		int unsigned     lim, h, s, m, k;
		longint unsigned off, c;
		elem_res_t       r;
		lim = (size_shadow > MAX_ELEMS) ? MAX_ELEMS : size_shadow;
		if (rank == 0 || cnt_tab[0][lim] <= rank) begin
			pending_elems.push_back(RANGE_ERR_RES);
			return;
		end
		// largest subset size whose tail count still fits under the index
		h = lim;
		for (k = 1; k <= lim; k++) begin
			if (cnt_tab[k][lim] <= rank) begin
				h = k;
				break;
			end
		end
		s = lim - h + 1;
		off = rank - cnt_tab[h][lim];
		// keep a position while the offset lies inside its coefficient
		m = 1;
		for (k = 1; k <= lim && m <= s; k++) begin
			c = cnt_tab[lim-k][s-m];
			if (off < c) begin
				r.value  = base_shadow[k-1];
				r.pos    = POS_W'(k - 1);
				r.size   = SIZE_W'(s);
				r.status = STAT_OK;
				r.last   = (m == s);
				pending_elems.push_back(r);
				m++;
			end else begin
				off -= c;
			end
		end
	endfunction

	// one request transfer; starts and ends at a falling edge, tvalid left high
	task automatic send_req(input logic kind, input logic [POS_W-1:0] slot,
			input logic [31:0] val, input logic [31:0] rank, input logic typed);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tuser  <= kind;
		s_axis_tdata  <= IN_TDATA_W'({rank, val, slot});
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		if (kind == REQ_LOAD) begin
			base_shadow[slot] = val;
		end else if (typed) begin
			pending_elems.push_back(RANGE_ERR_RES);
		end else begin
			unrank_predict(rank);
		end
		@(negedge clk);
	endtask

	// stop sending, wait for every expected transfer, then idle a while longer
	task automatic drain_results(input int unsigned extra);
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending_elems.size() != 0);
		repeat (extra) @(negedge clk);
	endtask

	// set size write, only ever issued with the block idle
	task automatic write_set_size(input logic [SIZE_W-1:0] v);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		size_shadow = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic cmp_field(input string what, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			mismatch_cnt++;
			$display("%0t: %s expected %0h got %0h", $time, what, want_v, got_v);
		end
	endtask

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// result checker: each element transfer against the oldest expectation
	always @(posedge clk) begin : result_check
		elem_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_elems.size() == 0) begin
				mismatch_cnt++;
				$display("%0t: unexpected transfer, expected none, got value %0h pos %0d",
					$time, m_axis_tdata[31:0], m_axis_tdata[36:32]);
			end else begin
				want = pending_elems.pop_front();
				cmp_field("elem_value", want.value, m_axis_tdata[31:0]);
				cmp_field("elem_pos", 32'(want.pos), 32'(m_axis_tdata[36:32]));
				cmp_field("subset_size", 32'(want.size), 32'(m_axis_tdata[42:37]));
				cmp_field("status", 32'(want.status), 32'(m_axis_tuser));
				cmp_field("last", 32'(want.last), 32'(m_axis_tlast));
			end
		end
	end

	// watchdog: too long without a transfer on any channel
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		int unsigned     pick, lim;
		longint unsigned top;
		logic [31:0]     rank;
		logic [SIZE_W-1:0] cfg_v;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// fill the whole base set first so no unwritten entry is ever read
		for (int i = 0; i < MAX_ELEMS; i++) begin
			send_req(REQ_LOAD, POS_W'(i), $urandom, $urandom, 1'b0);
		end

		foreach (dir_tab[i]) begin
			case (dir_tab[i].kind)
				ROW_CFG: begin
					drain_results(SETTLE_CYC);
					write_set_size(dir_tab[i].arg[SIZE_W-1:0]);
				end
				ROW_LOAD: begin
					send_req(REQ_LOAD, dir_tab[i].slot, dir_tab[i].value, $urandom, 1'b0);
				end
				default: begin
					send_req(REQ_UNRANK, POS_W'($urandom), $urandom, dir_tab[i].arg,
						dir_tab[i].typed);
				end
			endcase
		end

		// random traffic: receiver-heavy idling, then sender-heavy, then none
		for (int ph = 0; ph < 3; ph++) begin
			tx_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 75 : 0;
			rx_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 20 : 0;
			for (int blk = 0; blk < 3; blk++) begin
				pick = $urandom_range(99);
				if (pick < 10) begin
					cfg_v = '0;
				end else if (pick < 20) begin
					cfg_v = SIZE_W'($urandom_range(63, 33));
				end else if (pick < 35) begin
					cfg_v = SIZE_W'($urandom_range(2, 1));
				end else if (pick < 55) begin
					cfg_v = SIZE_W'(MAX_ELEMS);
				end else begin
					cfg_v = SIZE_W'($urandom_range(31, 3));
				end
				drain_results(SETTLE_CYC);
				write_set_size(cfg_v);
				lim = (size_shadow > MAX_ELEMS) ? MAX_ELEMS : size_shadow;
				top = (lim >= 32) ? 64'hFFFF_FFFF : (64'd1 << lim) - 1;

				for (int n = 0; n < 38; n++) begin
					// now and then hold off until the block has answered everything
					if ($urandom_range(99) < 4) drain_results(0);
					if ($urandom_range(99) < 25) begin
						send_req(REQ_LOAD, POS_W'($urandom), $urandom, $urandom, 1'b0);
					end else begin
						pick = $urandom_range(99);
						if (pick < 6) begin
							rank = '0;
						end else if (pick < 14) begin
							rank = $urandom;
						end else if (pick < 20 && top < 64'hFFFF_FFFF) begin
							rank = $urandom_range(32'hFFFF_FFFF, 32'(top + 1));
						end else if (top == 0) begin
							rank = $urandom;
						end else begin
							rank = $urandom_range(32'(top), 1);
						end
						send_req(REQ_UNRANK, POS_W'($urandom), $urandom, rank, 1'b0);
					end
				end
			end
		end

		drain_results(SETTLE_CYC);
		if (mismatch_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
